@@ sv/hrrn_pkg.sv @@
package hrrn_pkg;

  localparam int FIELD_W    = 16;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 5;
  localparam int IN_DATA_W  = 5 * FIELD_W;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_PAD_W  = OUT_DATA_W - 4 * FIELD_W - OCC_W;

  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_FIFO = 2'd1;
  localparam logic [OP_W-1:0] OP_HRRN = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

endpackage

@@ sv/hrrn_ram.sv @@
module hrrn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/hrrn_mul.sv @@
module hrrn_mul #(
  parameter int A_W = 18,
  parameter int B_W = 17
) (
  input  logic                        clk_i,
  input  logic signed [A_W-1:0]       a_i,
  input  logic signed [B_W-1:0]       b_i,
  output logic signed [A_W+B_W-1:0]   p_o
);

  logic signed [A_W+B_W-1:0] p_q;

  // product is registered, so it lands in the cycle after the operands
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

@@ sv/hrrn_ready_queue.sv @@
// HRRN ready queue.
// Input channel s_axis: tuser carries the op (enqueue, FIFO dequeue, ratio
// dequeue), tdata the time and job fields. Output channel m_axis: one item
// per input item, tuser carries the status, tdata the removed entry and
// the occupancy after the item.
// Entries sit in one RAM in arrival order. A ratio dequeue walks the
// occupied entries through one shared signed multiplier: two products per
// entry (w * best_r, best_w * r), compared exactly, ties keep the oldest.
// Removal closes the gap by copying entries down one slot over the RAM's
// single read and write port.
// A dequeue reads each scanned entry (RD, WT), then, past the first,
// forms its two products (M1, M2) and compares them (CMP); the shift
// then reads and writes each moved entry (SH_RD, SH_WR). One item is
// worked on at a time; s_axis_tready is high only while idle.
// A finished result is held in an output register; the next item is
// accepted while it waits, and a stalled receiver only holds back the
// following result. Reset empties the queue at once; RAM contents are not
// cleared.
module hrrn_ready_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // now, job_tag, arrive_tick, service_time, remaining_time
  input  logic [hrrn_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // op
  input  logic [hrrn_pkg::OP_W-1:0]        s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // out_tag, out_arrival, out_service, out_remaining, occupancy, zero pad
  output logic [hrrn_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // status
  output logic [hrrn_pkg::STATUS_W-1:0]    m_axis_tuser_o
);
  import hrrn_pkg::*;

  localparam int TW     = TIME_BITS;
  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int WAIT_W = TW + 2;
  localparam int REM_W  = TW + 1;
  localparam int PROD_W = WAIT_W + REM_W;
  localparam int WORD_W = FIELD_W + 3 * TW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_WT    = 4'd2;
  localparam logic [3:0] S_M1    = 4'd3;
  localparam logic [3:0] S_M2    = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_RM    = 4'd6;
  localparam logic [3:0] S_SH_RD = 4'd7;
  localparam logic [3:0] S_SH_WR = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]          state_q;
  logic [CNT_W-1:0]    count_q;
  logic                m_valid_q;

  logic [TW-1:0]       now_q;
  logic [CNT_W-1:0]    scan_end_q;
  logic [IDX_W-1:0]    idx_q;
  logic [IDX_W-1:0]    sh_q;

  logic signed [WAIT_W-1:0] cand_w_q;
  logic [TW-1:0]            cand_r_q;
  logic [WORD_W-1:0]        cand_data_q;
  logic signed [WAIT_W-1:0] best_w_q;
  logic [TW-1:0]            best_r_q;
  logic [WORD_W-1:0]        best_data_q;
  logic [IDX_W-1:0]         best_idx_q;
  logic signed [PROD_W-1:0] prod_cand_q;

  logic [STATUS_W-1:0] res_status_q;
  logic [WORD_W-1:0]   res_word_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // input fields
  logic          s_fire;
  logic [TW-1:0] in_now, in_arr, in_svc, in_rem, in_rem_cl;
  logic [FIELD_W-1:0] in_tag;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  assign in_now    = TW'(s_axis_tdata_i[0*FIELD_W +: FIELD_W]);
  assign in_tag    = s_axis_tdata_i[1*FIELD_W +: FIELD_W];
  assign in_arr    = TW'(s_axis_tdata_i[2*FIELD_W +: FIELD_W]);
  assign in_svc    = TW'(s_axis_tdata_i[3*FIELD_W +: FIELD_W]);
  assign in_rem    = TW'(s_axis_tdata_i[4*FIELD_W +: FIELD_W]);
  assign in_rem_cl = (in_rem == '0) ? TW'(1) : in_rem;

  // RAM port
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = IDX_W'(count_q);
    ram_wdata = {in_rem_cl, in_svc, in_arr, in_tag};
    ram_raddr = idx_q;
    case (state_q)
      S_IDLE: begin
        ram_we = s_fire && (s_axis_tuser_i == OP_ENQ) &&
                 (count_q < CNT_W'(QUEUE_DEPTH));
      end
      S_SH_RD: begin
        ram_raddr = IDX_W'(CNT_W'(sh_q) + 1'b1);
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sh_q;
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  hrrn_ram #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // fields of the entry just read
  logic [TW-1:0] rd_arr, rd_svc, rd_rem;
  logic signed [WAIT_W-1:0] rd_wait;

  assign rd_arr  = ram_rdata[FIELD_W +: TW];
  assign rd_svc  = ram_rdata[FIELD_W + TW +: TW];
  assign rd_rem  = ram_rdata[FIELD_W + 2*TW +: TW];
  // modular arithmetic; the true value always fits WAIT_W signed bits
  assign rd_wait = WAIT_W'(now_q) - WAIT_W'(rd_arr) - WAIT_W'(rd_svc) + WAIT_W'(rd_rem);

  // shared multiplier: M1 forms cand_w * best_r, M2 forms best_w * cand_r
  logic signed [WAIT_W-1:0] mul_a;
  logic signed [REM_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;

  assign mul_a = (state_q == S_M1) ? cand_w_q : best_w_q;
  assign mul_b = (state_q == S_M1) ? $signed({1'b0, best_r_q}) : $signed({1'b0, cand_r_q});

  hrrn_mul #(
    .A_W (WAIT_W),
    .B_W (REM_W)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  logic scan_last;
  assign scan_last = (CNT_W'(idx_q) + 1'b1 == scan_end_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && (!m_valid_q || m_axis_tready_i)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_fire) begin
            case (s_axis_tuser_i)
              OP_ENQ: begin
                if (count_q < CNT_W'(QUEUE_DEPTH)) begin
                  count_q <= count_q + 1'b1;
                end
                state_q <= S_OUT;
              end
              OP_FIFO, OP_HRRN: begin
                state_q <= (count_q == '0) ? S_OUT : S_RD;
              end
              default: begin
                state_q <= S_OUT;
              end
            endcase
          end
        end
        S_RD: state_q <= S_WT;
        S_WT: begin
          if (idx_q != '0) begin
            state_q <= S_M1;
          end else begin
            state_q <= scan_last ? S_RM : S_RD;
          end
        end
        S_M1:  state_q <= S_M2;
        S_M2:  state_q <= S_CMP;
        S_CMP: state_q <= scan_last ? S_RM : S_RD;
        S_RM: begin
          if (CNT_W'(best_idx_q) + 1'b1 < count_q) begin
            state_q <= S_SH_RD;
          end else begin
            count_q <= count_q - 1'b1;
            state_q <= S_OUT;
          end
        end
        S_SH_RD: state_q <= S_SH_WR;
        S_SH_WR: begin
          if (CNT_W'(sh_q) + CNT_W'(2) < count_q) begin
            state_q <= S_SH_RD;
          end else begin
            count_q <= count_q - 1'b1;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          now_q        <= in_now;
          idx_q        <= '0;
          scan_end_q   <= (s_axis_tuser_i == OP_HRRN) ? count_q : CNT_W'(1);
          res_word_q   <= '0;
          if (s_axis_tuser_i == OP_ENQ && count_q >= CNT_W'(QUEUE_DEPTH)) begin
            res_status_q <= STAT_FULL;
          end else if ((s_axis_tuser_i inside {OP_FIFO, OP_HRRN}) &&
                       count_q == '0) begin
            res_status_q <= STAT_EMPTY;
          end else begin
            res_status_q <= STAT_OK;
          end
        end
      end
      S_WT: begin
        cand_w_q    <= rd_wait;
        cand_r_q    <= rd_rem;
        cand_data_q <= ram_rdata;
        if (idx_q == '0) begin
          // first entry is the initial best
          best_w_q    <= rd_wait;
          best_r_q    <= rd_rem;
          best_data_q <= ram_rdata;
          best_idx_q  <= '0;
          if (!scan_last) begin
            idx_q <= idx_q + 1'b1;
          end
        end
      end
      S_M2: begin
        prod_cand_q <= mul_p;
      end
      S_CMP: begin
        // strict compare: ties keep the older entry
        if (prod_cand_q > mul_p) begin
          best_w_q    <= cand_w_q;
          best_r_q    <= cand_r_q;
          best_data_q <= cand_data_q;
          best_idx_q  <= idx_q;
        end
        if (!scan_last) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      S_RM: begin
        res_word_q <= best_data_q;
        sh_q       <= best_idx_q;
      end
      S_SH_WR: begin
        sh_q <= sh_q + 1'b1;
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_status_q <= res_status_q;
          out_data_q   <= {{OUT_PAD_W{1'b0}},
                           OCC_W'(count_q),
                           FIELD_W'(res_word_q[FIELD_W + 2*TW +: TW]),
                           FIELD_W'(res_word_q[FIELD_W + TW +: TW]),
                           FIELD_W'(res_word_q[FIELD_W +: TW]),
                           res_word_q[FIELD_W-1:0]};
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> (count_q == $past(count_q) + 1'b1) ||
                          (count_q + 1'b1 == $past(count_q)))
    else $error("queue count moved by more than one");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (CNT_W'(idx_q) < scan_end_q) && (scan_end_q <= count_q))
    else $error("scan reads beyond occupied entries");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SH_WR) |-> (CNT_W'(sh_q) + 1'b1 < count_q))
    else $error("shift writes beyond occupied entries");

  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_M1) |-> (best_r_q != '0) && (cand_r_q != '0))
    else $error("zero remaining time reached the ratio compare");
`endif

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import hrrn_pkg::*;

  localparam int DEPTH = 16;
  localparam int RUN_ITEMS = 900;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 150;
  // unused op code: the block leaves the queue as it is and still answers it
  localparam logic [OP_W-1:0] OP_IDLE = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  tag;
    logic [FIELD_W-1:0]  arrival;
    logic [FIELD_W-1:0]  service;
    logic [FIELD_W-1:0]  remaining;
    logic [OCC_W-1:0]    occ;
  } sched_result_t;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] now;
    logic [FIELD_W-1:0] tag;
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] service;
    logic [FIELD_W-1:0] remaining;
    bit                 has_exp;
    sched_result_t      exp;
  } job_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_valid = 1'b0;
  logic [IN_DATA_W-1:0]  s_data = '0;
  logic [OP_W-1:0]       s_op = OP_ENQ;
  logic                  m_ready = 1'b0;
  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [STATUS_W-1:0]   m_axis_tuser_o;

  // predictor copy of the ready queue
  logic [FIELD_W-1:0] q_tag [DEPTH];
  logic [FIELD_W-1:0] q_arr [DEPTH];
  logic [FIELD_W-1:0] q_srv [DEPTH];
  logic [FIELD_W-1:0] q_rem [DEPTH];
  int                 q_count = 0;

  sched_result_t pending_results [$];
  job_row_t      dir_rows [$];
  int            errors = 0;
  int            results_seen = 0;
  bit            no_gaps = 1'b0;

  hrrn_ready_queue DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    // now, job_tag, arrive_tick, service_time, remaining_time
    .s_axis_tdata_i  (s_data),
    // op
    .s_axis_tuser_i  (s_op),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    // out_tag, out_arrival, out_service, out_remaining, occupancy, zero pad
    .m_axis_tdata_o  (m_axis_tdata_o),
    // status
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic sched_result_t hrrn_predict(
    logic [OP_W-1:0] op, logic [FIELD_W-1:0] now, logic [FIELD_W-1:0] tag,
    logic [FIELD_W-1:0] arr, logic [FIELD_W-1:0] srv, logic [FIELD_W-1:0] rem);
    sched_result_t r;
    int pick;
    longint best_w, best_r, w, rr;
    r = '0;
    case (op)
      OP_ENQ: begin
        if (q_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          q_tag[q_count] = tag;
          q_arr[q_count] = arr;
          q_srv[q_count] = srv;
          q_rem[q_count] = (rem == '0) ? 16'd1 : rem;
          q_count++;
        end
      end
      OP_FIFO, OP_HRRN: begin
        if (q_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          pick = 0;
          if (op == OP_HRRN) begin
            best_w = longint'(now) - longint'(q_arr[0]) - longint'(q_srv[0])
                     + longint'(q_rem[0]);
            best_r = longint'(q_rem[0]);
            for (int i = 1; i < q_count; i++) begin
              w = longint'(now) - longint'(q_arr[i]) - longint'(q_srv[i])
                  + longint'(q_rem[i]);
              rr = longint'(q_rem[i]);
              // strictly greater only, so ties stay with the older entry
              if (w * best_r > best_w * rr) begin
                pick = i;
                best_w = w;
                best_r = rr;
              end
            end
          end
          r.tag = q_tag[pick];
          r.arrival = q_arr[pick];
          r.service = q_srv[pick];
          r.remaining = q_rem[pick];
          for (int i = pick; i < q_count - 1; i++) begin
            q_tag[i] = q_tag[i + 1];
            q_arr[i] = q_arr[i + 1];
            q_srv[i] = q_srv[i + 1];
            q_rem[i] = q_rem[i + 1];
          end
          q_count--;
        end
      end
      default: ;
    endcase
    r.occ = OCC_W'(q_count);
    return r;
  endfunction

  task automatic add_row(logic [OP_W-1:0] op, logic [FIELD_W-1:0] now,
                         logic [FIELD_W-1:0] tag, logic [FIELD_W-1:0] arr,
                         logic [FIELD_W-1:0] srv, logic [FIELD_W-1:0] rem,
                         bit has_exp, logic [STATUS_W-1:0] st, int occ);
    job_row_t row;
    row.op = op;
    row.now = now;
    row.tag = tag;
    row.arrival = arr;
    row.service = srv;
    row.remaining = rem;
    row.has_exp = has_exp;
    row.exp = '0;
    row.exp.status = st;
    row.exp.occ = OCC_W'(occ);
    dir_rows.push_back(row);
  endtask

  // offers one item, returns once it is accepted
  task automatic send_job(job_row_t row);
    sched_result_t predicted;
    while (!no_gaps && $urandom_range(99) < 23) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_op <= row.op;
    s_data <= {row.remaining, row.service, row.arrival, row.tag, row.now};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = hrrn_predict(row.op, row.now, row.tag, row.arrival, row.service,
                             row.remaining);
    pending_results.push_back(row.has_exp ? row.exp : predicted);
  endtask

  function automatic logic [FIELD_W-1:0] pick_time();
    int r = $urandom_range(99);
    if (r < 8) return 16'h0000;
    if (r < 16) return 16'hFFFF;
    if (r < 60) return FIELD_W'($urandom_range(400));
    return FIELD_W'($urandom);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_remaining();
    int r = $urandom_range(99);
    if (r < 10) return 16'h0000;
    if (r < 15) return 16'hFFFF;
    if (r < 70) return FIELD_W'($urandom_range(1, 20));
    return FIELD_W'($urandom);
  endfunction

  always @(posedge clk_i) begin
    sched_result_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got.status = m_axis_tuser_o;
      got.tag = m_axis_tdata_o[15:0];
      got.arrival = m_axis_tdata_o[31:16];
      got.service = m_axis_tdata_o[47:32];
      got.remaining = m_axis_tdata_o[63:48];
      got.occ = m_axis_tdata_o[68:64];
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: st=%0d tag=%h arr=%h srv=%h rem=%h occ=%0d",
                   got.status, got.tag, got.arrival, got.service, got.remaining,
                   got.occ);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch exp: st=%0d tag=%h arr=%h srv=%h rem=%h occ=%0d",
                     want.status, want.tag, want.arrival, want.service,
                     want.remaining, want.occ);
            $display("         got: st=%0d tag=%h arr=%h srv=%h rem=%h occ=%0d",
                     got.status, got.tag, got.arrival, got.service,
                     got.remaining, got.occ);
          end
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off to back the block up
  initial begin : rx_side
    bit held;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && results_seen >= 200) begin
        held = 1'b1;
        m_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end
      m_ready <= no_gaps || ($urandom_range(99) >= 23);
    end
  end

  initial begin : stimulus
    job_row_t row;
    int sent;
    int enq_pct;
    int r;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue, ignored op, fill to full with extremes, enqueue when full, then removals and an ignored op
    add_row(OP_FIFO, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, STAT_EMPTY, 0);
    add_row(OP_HRRN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, STAT_EMPTY, 0);
    add_row(OP_IDLE, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0001, 1'b1, STAT_OK, 0);
    add_row(OP_ENQ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, STAT_OK, 1);
    add_row(OP_ENQ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, STAT_OK, 2);
    add_row(OP_ENQ, 16'h0000, 16'h1234, 16'h0064, 16'h0032, 16'h000A, 1'b1, STAT_OK, 3);
    add_row(OP_ENQ, 16'h0000, 16'h1235, 16'h0064, 16'h0032, 16'h000A, 1'b1, STAT_OK, 4);
    add_row(OP_ENQ, 16'h0000, 16'hA5A5, 16'h0000, 16'hFFFF, 16'h0001, 1'b1, STAT_OK, 5);
    add_row(OP_ENQ, 16'h0000, 16'h0010, 16'h0040, 16'h0020, 16'h0020, 1'b1, STAT_OK, 6);
    add_row(OP_ENQ, 16'h0000, 16'h0011, 16'h0050, 16'h0010, 16'h0005, 1'b1, STAT_OK, 7);
    add_row(OP_ENQ, 16'h0000, 16'h0012, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, STAT_OK, 8);
    add_row(OP_ENQ, 16'h0000, 16'h0013, 16'h8000, 16'h0001, 16'h0002, 1'b1, STAT_OK, 9);
    add_row(OP_ENQ, 16'h0000, 16'h0014, 16'h0030, 16'h0030, 16'h0003, 1'b1, STAT_OK, 10);
    add_row(OP_ENQ, 16'h0000, 16'h0015, 16'h0031, 16'h0006, 16'h0002, 1'b1, STAT_OK, 11);
    add_row(OP_ENQ, 16'h0000, 16'h0016, 16'h0010, 16'h0008, 16'h0004, 1'b1, STAT_OK, 12);
    add_row(OP_ENQ, 16'h0000, 16'h0017, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b1, STAT_OK, 13);
    add_row(OP_ENQ, 16'h0000, 16'h0018, 16'h0020, 16'h0000, 16'h0001, 1'b1, STAT_OK, 14);
    add_row(OP_ENQ, 16'h0000, 16'h0019, 16'h0020, 16'h0000, 16'h0001, 1'b1, STAT_OK, 15);
    add_row(OP_ENQ, 16'h0000, 16'h001A, 16'h00C8, 16'h0064, 16'h0032, 1'b1, STAT_OK, 16);
    add_row(OP_ENQ, 16'h0000, 16'hBEEF, 16'h0001, 16'h0002, 16'h0003, 1'b1, STAT_FULL, 16);
    add_row(OP_HRRN, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, STAT_OK, 0);
    add_row(OP_HRRN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, STAT_OK, 0);
    add_row(OP_FIFO, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, STAT_OK, 0);
    add_row(OP_HRRN, 16'h00C8, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, STAT_OK, 0);
    add_row(OP_IDLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, STAT_OK, 0);
    foreach (dir_rows[i]) send_job(dir_rows[i]);

    // random part: the enqueue share moves so the queue fills and drains
    sent = 0;
    while (sent < RUN_ITEMS) begin
      case ((sent / 60) % 4)
        0: enq_pct = 85;
        1: enq_pct = 50;
        2: enq_pct = 15;
        default: enq_pct = 60;
      endcase
      r = $urandom_range(99);
      row.has_exp = 1'b0;
      row.exp = '0;
      row.now = pick_time();
      row.tag = FIELD_W'($urandom);
      row.arrival = pick_time();
      row.service = pick_time();
      row.remaining = pick_remaining();
      if (r < 2)
        row.op = OP_IDLE;
      else if (r < enq_pct)
        row.op = OP_ENQ;
      else
        row.op = ($urandom_range(99) < 70) ? OP_HRRN : OP_FIFO;
      send_job(row);
      if (row.op != OP_IDLE) sent++;
      no_gaps = (sent >= 400 && sent < 550);
    end
    s_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ hrrn_ready_queue.f @@
sv/hrrn_pkg.sv
sv/hrrn_ram.sv
sv/hrrn_mul.sv
sv/hrrn_ready_queue.sv
test/tb_top.sv
